FILE: design/ssd_pkg.sv
// Shared types, constants and helper functions for the seven-segment serial driver.
// Used by ssd_digit_pipe, ssd_frame, ssd_serial and the top level; no dependencies.
package ssd_pkg;

  localparam int DIGIT_MAX       = 4;
  localparam int DIGIT_COUNT_DEF = 4;
  localparam int FRAME_BITS      = 16;
  // one divide-by-ten stage per digit plus one stage to finish the top digit
  localparam int DIV_STAGES      = DIGIT_MAX + 1;

  // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
  localparam logic [31:0] RECIP10       = 32'd52429;
  localparam int          RECIP10_SHIFT = 19;

  typedef enum logic {
    KIND_NUMBER = 1'b0,
    KIND_RAW    = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                       kind;
    logic [7:0]                  raw_segments;
    logic [1:0]                  digit_index;
    logic [15:0]                 prev;
    logic [15:0]                 quo;
    logic [DIGIT_MAX-1:0][3:0]   digits;
  } conv_t;

  function automatic logic [15:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * RECIP10;
    return 16'(p >> RECIP10_SHIFT);
  endfunction

  // prev - 10 * quo, where quo == prev / 10
  function automatic logic [3:0] low_digit(input logic [15:0] prev, input logic [15:0] quo);
    logic [15:0] r;
    r = prev - ((quo << 3) + (quo << 1));
    return r[3:0];
  endfunction

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hFC;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hDA;
      4'd3:    s = 8'hF2;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'hB6;
      4'd6:    s = 8'hBE;
      4'd7:    s = 8'hE0;
      4'd8:    s = 8'hFE;
      4'd9:    s = 8'hF6;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // active-low digit enable: inverse of 0x10 shifted by the digit index
  function automatic logic [7:0] enable_of(input logic [1:0] idx);
    logic [7:0] sel;
    sel = 8'h10 << idx;
    return ~sel;
  endfunction

endpackage

FILE: design/ssd_digit_pipe.sv
// Binary to decimal conversion pipeline: an input register, then one multiply-by-reciprocal divide per stage.
// Depends on ssd_pkg.
module ssd_digit_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssd_pkg::kind_t      kind,
  input  logic [15:0]         value,
  input  logic [7:0]          raw_segments,
  input  logic [1:0]          digit_index,
  output logic                out_valid,
  input  logic                out_ready,
  output ssd_pkg::conv_t      out_conv
);

  localparam int N = ssd_pkg::DIV_STAGES + 1;

  ssd_pkg::conv_t stg [N];
  ssd_pkg::conv_t nxt [N];
  logic [N-1:0]   vld;
  logic [N-1:0]   upv;
  logic [N-1:0]   adv;

  always_comb begin
    // a stage loads when it is empty or its word moves on this cycle
    adv[N-1] = !vld[N-1] || out_ready;
    for (int j = N - 2; j >= 0; j--) begin
      adv[j] = !vld[j] || adv[j+1];
    end
    upv[0] = in_valid;
    for (int j = 1; j < N; j++) begin
      upv[j] = vld[j-1];
    end
  end

  always_comb begin
    nxt[0].kind         = kind;
    nxt[0].raw_segments = raw_segments;
    nxt[0].digit_index  = digit_index;
    nxt[0].prev         = '0;
    nxt[0].quo          = value;
    nxt[0].digits       = '0;
    for (int j = 1; j < N; j++) begin
      nxt[j]      = stg[j-1];
      nxt[j].prev = stg[j-1].quo;
      nxt[j].quo  = ssd_pkg::div10(stg[j-1].quo);
      if (j >= 2) begin
        nxt[j].digits[2'(j-2)] = ssd_pkg::low_digit(stg[j-1].prev, stg[j-1].quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int j = 0; j < N; j++) begin
        if (adv[j]) begin
          vld[j] <= upv[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < N; j++) begin
      if (adv[j] && upv[j]) begin
        stg[j] <= nxt[j];
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[N-1];
  assign out_conv  = stg[N-1];

endmodule

FILE: design/ssd_frame.sv
// Frame builder: segment lookup and digit enable byte for each 16-bit frame.
// Depends on ssd_pkg.
module ssd_frame #(
  parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  ssd_pkg::conv_t                            in_conv,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output ssd_pkg::kind_t                            out_kind,
  output logic [ssd_pkg::FRAME_BITS*DIGIT_COUNT-1:0] out_words
);

  localparam int FB = ssd_pkg::FRAME_BITS;

  logic                          vld;
  ssd_pkg::kind_t                kind;
  logic [FB*DIGIT_COUNT-1:0]     words;
  logic [FB*DIGIT_COUNT-1:0]     words_next;

  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      words_next[i*FB +: FB] = {ssd_pkg::enable_of(2'(i)), ssd_pkg::seg_of(in_conv.digits[i])};
    end
    // raw word always goes out as the first frame
    if (in_conv.kind == ssd_pkg::KIND_RAW) begin
      words_next[FB-1:0] = {ssd_pkg::enable_of(in_conv.digit_index), in_conv.raw_segments};
    end
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      kind  <= in_conv.kind;
      words <= words_next;
    end
  end

  assign out_valid = vld;
  assign out_kind  = kind;
  assign out_words = words;

endmodule

FILE: design/ssd_serial.sv
// Output shifter: sends the frames of one request LSB first, one bit per word.
// Depends on ssd_pkg.
module ssd_serial #(
  parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  ssd_pkg::kind_t                            in_kind,
  input  logic [ssd_pkg::FRAME_BITS*DIGIT_COUNT-1:0] in_words,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic                                      serial_bit,
  output logic                                      latch_strobe,
  output logic                                      last
);

  localparam int SH_W  = ssd_pkg::FRAME_BITS * DIGIT_COUNT;
  localparam int CNT_W = $clog2(SH_W + 1);
  localparam int POS_W = $clog2(ssd_pkg::FRAME_BITS);

  logic             busy;
  logic [SH_W-1:0]  sh;
  logic [CNT_W-1:0] left;
  logic [POS_W-1:0] pos;
  logic             take;
  logic             finish;
  logic             load;

  assign out_valid    = busy;
  assign serial_bit   = sh[0];
  assign latch_strobe = (pos == POS_W'(ssd_pkg::FRAME_BITS - 1));
  assign last         = (left == CNT_W'(1));

  assign take     = busy && out_ready;
  assign finish   = take && last;
  assign in_ready = !busy || finish;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh   <= in_words;
      left <= (in_kind == ssd_pkg::KIND_RAW) ? CNT_W'(ssd_pkg::FRAME_BITS) : CNT_W'(SH_W);
      pos  <= '0;
    end else if (take) begin
      // advance one bit; pos wraps at the frame boundary
      sh   <= sh >> 1;
      left <= left - CNT_W'(1);
      pos  <= pos + POS_W'(1);
    end
  end

endmodule

FILE: design/seven_segment_serial_driver_core.sv
// Seven-segment serial driver top level: digit pipeline, frame builder, output shifter.
// Depends on ssd_pkg, ssd_digit_pipe, ssd_frame and ssd_serial.

// A request is accepted on in_valid/in_ready and produces one output word per serial
// bit: 16 * DIGIT_COUNT words for a number request, 16 for a raw request, one word per
// cycle while out_ready is high. The output shifter sends one bit per cycle while out_ready
// is high. When nothing stalls, the first bit of a request passes one input register, five
// divide-by-ten stages, the frame stage and the shifter load. Up to seven further requests
// wait in the pipeline stages while the shifter is busy.
module seven_segment_serial_driver_core #(
  parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [15:0] value,
  input  logic [7:0]  raw_segments,
  input  logic [1:0]  digit_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        serial_bit,
  output logic        latch_strobe,
  output logic        last
);

  localparam int SH_W = ssd_pkg::FRAME_BITS * DIGIT_COUNT;

  logic             conv_valid;
  logic             conv_ready;
  ssd_pkg::conv_t   conv;
  logic             frm_valid;
  logic             frm_ready;
  ssd_pkg::kind_t   frm_kind;
  logic [SH_W-1:0]  frm_words;

  ssd_digit_pipe u_digit (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (ssd_pkg::kind_t'(kind)),
    .value        (value),
    .raw_segments (raw_segments),
    .digit_index  (digit_index),
    .out_valid    (conv_valid),
    .out_ready    (conv_ready),
    .out_conv     (conv)
  );

  ssd_frame #(.DIGIT_COUNT(DIGIT_COUNT)) u_frame (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (conv_valid),
    .in_ready  (conv_ready),
    .in_conv   (conv),
    .out_valid (frm_valid),
    .out_ready (frm_ready),
    .out_kind  (frm_kind),
    .out_words (frm_words)
  );

  ssd_serial #(.DIGIT_COUNT(DIGIT_COUNT)) u_serial (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (frm_valid),
    .in_ready     (frm_ready),
    .in_kind      (frm_kind),
    .in_words     (frm_words),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .serial_bit   (serial_bit),
    .latch_strobe (latch_strobe),
    .last         (last)
  );

  // the final bit of a request always closes a frame
  a_last_on_frame_end : assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> latch_strobe)
    else $error("last word does not close a frame");

  // a request keeps the output busy until its last bit is taken
  a_no_gap_in_request : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("output went idle in the middle of a request");

  // a frame boundary inside a request starts a fresh frame
  a_frame_restart : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && latch_strobe && !last |=> out_valid && !latch_strobe)
    else $error("latch strobe repeated after a frame boundary");

endmodule
